FILE: hdl/hbnc_pkg.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: shared package
// Item kinds, character codes, status codes and register reset values.
// ----------------------------------------------------------------------------
package hbnc_pkg;

    localparam int OUT_W = 16;

    // Kind of input beat (carried in s_tuser).
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result status (carried in m_tuser).
    localparam logic STATUS_APPLIED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_MAX = 8'd9;

    localparam logic [OUT_W-1:0] MODULUS_RESET = 16'd10000;

endpackage

FILE: hdl/hbnc_front.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: response parser
// Walks the header, accumulates the decimal number of the first body line and
// hands one finished request to the queue at each end-of-response beat.
// ----------------------------------------------------------------------------
module hbnc_front #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [7:0]             data_byte,
    input  logic                   queue_full,
    output logic                   push,
    output logic                   push_bad,
    output logic [NUMBER_BITS-1:0] push_number
);
    import hbnc_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prev_reg, prev_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   bad_reg, bad_next;

    logic                   accept;
    logic [7:0]             digit;
    logic [NUMBER_BITS+3:0] acc_wide;

    assign in_ready    = !queue_full;
    assign accept      = in_valid && in_ready;
    assign push        = accept && (op == OP_END);
    assign push_bad    = bad_reg;
    assign push_number = acc_reg;

    assign digit = data_byte - CH_ZERO;
    // Times ten as two shifts, plus the digit.
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + (NUMBER_BITS + 4)'(digit[3:0]);

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        if (accept)
        begin
            if (op == OP_END)
            begin
                phase_next = PH_HEADER;
                prev_next  = '0;
                acc_next   = '0;
                bad_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (data_byte != CH_CR)
                        begin
                            if (prev_reg == CH_LF && data_byte == CH_LF)
                                phase_next = PH_BODY;
                            else
                                prev_next = data_byte;
                        end
                    end
                    PH_BODY:
                    begin
                        if (data_byte == CH_CR || data_byte == CH_LF)
                            phase_next = PH_DONE;
                        else if (digit > DIGIT_MAX)
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (acc_wide[NUMBER_BITS+3:NUMBER_BITS] != 4'd0)
                            acc_next = NUM_MAX;
                        else
                            acc_next = acc_wide[NUMBER_BITS-1:0];
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            prev_reg  <= '0;
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            acc_reg   <= acc_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

FILE: hdl/hbnc_queue.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: request queue
// Two-entry queue of finished requests between the parser and the updater.
// ----------------------------------------------------------------------------
module hbnc_queue #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   push_bad,
    input  logic [NUMBER_BITS-1:0] push_number,
    output logic                   full,
    output logic                   not_empty,
    input  logic                   pop,
    output logic                   pop_bad,
    output logic [NUMBER_BITS-1:0] pop_number
);
    logic [NUMBER_BITS:0] entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign not_empty  = (count_reg != 2'd0);
    assign pop_bad    = entry_reg[rd_ptr_reg][NUMBER_BITS];
    assign pop_number = entry_reg[rd_ptr_reg][NUMBER_BITS-1:0];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= {push_bad, push_number};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/hbnc_back.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: counter updater
// Holds the modulus and the shown value, works out the click count (directly
// or with a bit-serial remainder unit) and drives the result register.
// ----------------------------------------------------------------------------
module hbnc_back #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hbnc_pkg::OUT_W-1:0]      cfg_wdata,
    input  logic                            req_valid,
    output logic                            req_pop,
    input  logic                            req_bad,
    input  logic [NUMBER_BITS-1:0]          req_number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_status,
    output logic [hbnc_pkg::OUT_W-1:0]      out_clicks,
    output logic [hbnc_pkg::OUT_W-1:0]      out_shown
);
    import hbnc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    localparam int CMP_W = (NUMBER_BITS > OUT_W) ? NUMBER_BITS : OUT_W;
    localparam logic [CMP_W-1:0] OUT_MAX_X = CMP_W'({OUT_W{1'b1}});
    localparam logic [3:0] LAST_STEP = 4'(OUT_W - 1);

    state_t             state_reg;
    logic [OUT_W-1:0]   modulus_reg;
    logic [OUT_W-1:0]   current_reg;
    logic [OUT_W-1:0]   m_reg;
    logic [OUT_W-1:0]   dvd_reg;
    logic [OUT_W-1:0]   rem_reg;
    logic [3:0]         step_reg;
    logic               bad_reg;
    logic [OUT_W-1:0]   clicks_reg;
    logic [OUT_W-1:0]   new_value_reg;
    logic               out_valid_reg;
    logic               out_status_reg;
    logic [OUT_W-1:0]   out_clicks_reg;
    logic [OUT_W-1:0]   out_shown_reg;

    logic [CMP_W-1:0]   target_x;
    logic [CMP_W-1:0]   from_x;
    logic [CMP_W-1:0]   diff_x;
    logic [OUT_W-1:0]   target_sat;
    logic [OUT_W:0]     rem_shift;
    logic [OUT_W:0]     rem_sub;
    logic [OUT_W-1:0]   rem_next;
    logic               emit_ok;

    assign target_x   = CMP_W'(req_number);
    assign from_x     = CMP_W'(current_reg);
    assign diff_x     = target_x - from_x;
    assign target_sat = (target_x > OUT_MAX_X) ? {OUT_W{1'b1}} : target_x[OUT_W-1:0];

    // One restoring remainder step per cycle, most significant bit first.
    assign rem_shift = {rem_reg, dvd_reg[OUT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, m_reg};
    assign rem_next  = rem_sub[OUT_W] ? rem_shift[OUT_W-1:0] : rem_sub[OUT_W-1:0];

    assign req_pop = (state_reg == ST_IDLE) && req_valid;
    assign emit_ok = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_clicks = out_clicks_reg;
    assign out_shown  = out_shown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            modulus_reg    <= MODULUS_RESET;
            current_reg    <= '0;
            out_valid_reg  <= 1'b0;
            m_reg          <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            step_reg       <= '0;
            bad_reg        <= 1'b0;
            clicks_reg     <= '0;
            new_value_reg  <= '0;
            out_status_reg <= STATUS_APPLIED;
            out_clicks_reg <= '0;
            out_shown_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                modulus_reg <= cfg_wdata;
            // In the emit state the output register is refilled instead.
            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        bad_reg       <= req_bad;
                        new_value_reg <= target_sat;
                        // A zero modulus behaves as one.
                        m_reg   <= (modulus_reg == '0) ? OUT_W'(1) : modulus_reg;
                        // Backward distance (from - target) as ~diff + 1.
                        dvd_reg <= (diff_x[OUT_W-1:0] ^ {OUT_W{1'b1}}) + OUT_W'(1);
                        rem_reg <= '0;
                        step_reg <= '0;
                        if (req_bad)
                        begin
                            clicks_reg <= '0;
                            state_reg  <= ST_EMIT;
                        end
                        else if (target_x >= from_x)
                        begin
                            clicks_reg <= (diff_x > OUT_MAX_X) ? {OUT_W{1'b1}}
                                                               : diff_x[OUT_W-1:0];
                            state_reg  <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // The backward distance is the negated difference, loaded
                    // as its twos complement.
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[OUT_W-2:0], 1'b0};
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        clicks_reg <= (rem_next == '0) ? '0 : (m_reg - rem_next);
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_clicks_reg <= clicks_reg;
                        if (bad_reg)
                        begin
                            out_status_reg <= STATUS_REJECTED;
                            out_shown_reg  <= current_reg;
                        end
                        else
                        begin
                            out_status_reg <= STATUS_APPLIED;
                            out_shown_reg  <= new_value_reg;
                            current_reg    <= new_value_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/http_body_number_to_click_count.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count
// Parses an HTTP response byte stream and turns the number on the first body
// line into a click count for a wrapping mechanical counter.
// ----------------------------------------------------------------------------
// Input channel (s_*): one beat per response byte with s_tuser = 0, then one
// end-of-response beat with s_tuser = 1. Byte beats give no result; each end
// beat gives exactly one result beat on the output channel (m_*): the status
// in m_tuser, the click count and the new shown value in m_tdata.
// A byte beat is absorbed by the parser. An end beat passes through a
// two-entry request queue to the updater; a forward step goes from the idle
// state through the emit state to the output register, and a backward step
// first runs a bit-serial remainder. The remainder loop sets the rate
// for end beats. s_tready drops only while the request queue is full.
// If the receiver stalls, the result stays in the output register, the
// updater holds its next result, and the parser keeps taking bytes until the
// queue fills. The user must write the modulus through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this. Reset: modulus
// 10000, shown value 0, parser in the header phase, no result pending.
// ----------------------------------------------------------------------------
module http_body_number_to_click_count #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hbnc_pkg::OUT_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic [0:0]                  s_tuser,   // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [15:0] click_count, [31:16] shown_value
    output logic [0:0]                  m_tuser    // [0] status
);
    import hbnc_pkg::*;

    logic                   queue_full;
    logic                   push;
    logic                   push_bad;
    logic [NUMBER_BITS-1:0] push_number;
    logic                   not_empty;
    logic                   pop;
    logic                   pop_bad;
    logic [NUMBER_BITS-1:0] pop_number;
    logic                   out_status;
    logic [OUT_W-1:0]       out_clicks;
    logic [OUT_W-1:0]       out_shown;

    hbnc_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (s_tuser[0]),
        .data_byte   (s_tdata),
        .queue_full  (queue_full),
        .push        (push),
        .push_bad    (push_bad),
        .push_number (push_number)
    );

    hbnc_queue #(.NUMBER_BITS(NUMBER_BITS)) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bad    (push_bad),
        .push_number (push_number),
        .full        (queue_full),
        .not_empty   (not_empty),
        .pop         (pop),
        .pop_bad     (pop_bad),
        .pop_number  (pop_number)
    );

    hbnc_back #(.NUMBER_BITS(NUMBER_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (not_empty),
        .req_pop    (pop),
        .req_bad    (pop_bad),
        .req_number (pop_number),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_clicks (out_clicks),
        .out_shown  (out_shown)
    );

    assign m_tdata = {out_shown, out_clicks};
    assign m_tuser = out_status;

endmodule

FILE: tb/sv/hbnc_checker.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: checker
// Watches the register port and both stream channels, keeps its own copy of
// the parser and counter state, predicts one result per end beat, and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hbnc_checker #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hbnc_pkg::OUT_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic [0:0]                  s_tuser,   // [0] op
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [31:0]                 m_tdata,   // [15:0] click_count, [31:16] shown_value
    input  logic [0:0]                  m_tuser,   // [0] status
    output int                          mismatches,
    output int                          awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import hbnc_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY_LINE,
        PH_LINE_DONE
    } parse_phase_t;

    typedef struct packed {
        logic             status;
        logic [OUT_W-1:0] clicks;
        logic [OUT_W-1:0] shown;
    } click_result_t;

    localparam logic [63:0] NUMBER_MAX = (64'd1 << NUMBER_BITS) - 64'd1;
    localparam logic [63:0] OUT_MAX    = (64'd1 << OUT_W) - 64'd1;

    parse_phase_t     phase;
    logic [7:0]       last_header_byte;
    logic [63:0]      body_number;
    logic             bad_digit;
    logic [OUT_W-1:0] counter_value;
    logic [OUT_W-1:0] modulus;

    click_result_t    clicks_due[$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_parser();
        phase            = PH_HEADER;
        last_header_byte = '0;
        body_number      = '0;
        bad_digit        = 1'b0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [7:0]  digit;
        logic [63:0] grown;
        digit = b - CH_ZERO;
        case (phase)
            PH_HEADER:
            begin
                if (b != CH_CR)
                begin
                    if (last_header_byte == CH_LF && b == CH_LF)
                        phase = PH_BODY_LINE;
                    else
                        last_header_byte = b;
                end
            end
            PH_BODY_LINE:
            begin
                if (b == CH_CR || b == CH_LF)
                    phase = PH_LINE_DONE;
                else if (digit > DIGIT_MAX)
                begin
                    bad_digit = 1'b1;
                    phase     = PH_LINE_DONE;
                end
                else
                begin
                    grown       = body_number * 64'd10 + 64'(digit);
                    body_number = (grown > NUMBER_MAX) ? NUMBER_MAX : grown;
                end
            end
            default:
            begin
                // Bytes after the end of the line or a rejection are dropped.
            end
        endcase
    endfunction

    // Steps forward directly; a backward step wraps through the modulus.
    function automatic logic [63:0] clicks_between(input logic [63:0] target,
                                                   input logic [63:0] from);
        logic [63:0] wrap;
        logic [63:0] rem;
        wrap = (modulus == '0) ? 64'd1 : 64'(modulus);
        if (target >= from)
            return target - from;
        rem = (from - target) % wrap;
        return (rem != 0) ? wrap - rem : 64'd0;
    endfunction

    function automatic click_result_t settle_response();
        click_result_t r;
        logic [63:0]   steps;
        if (bad_digit)
        begin
            r.status = STATUS_REJECTED;
            r.clicks = '0;
            r.shown  = counter_value;
        end
        else
        begin
            steps         = clicks_between(body_number, 64'(counter_value));
            counter_value = (body_number > OUT_MAX) ? OUT_MAX[OUT_W-1:0]
                                                    : body_number[OUT_W-1:0];
            r.status = STATUS_APPLIED;
            r.clicks = (steps > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : steps[OUT_W-1:0];
            r.shown  = counter_value;
        end
        clear_parser();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        click_result_t want;
        if (!rst_n)
        begin
            clear_parser();
            counter_value = '0;
            modulus       = MODULUS_RESET;
            clicks_due.delete();
            mismatches    = 0;
            awaiting      = 0;
        end
        else
        begin
            if (cfg_we)
                modulus = cfg_wdata;

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == OP_END)
                    clicks_due.push_back(settle_response());
                else
                    parse_byte(s_tdata);
            end

            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (clicks_due.size() == 0)
                    report_mismatch($sformatf("result beat with nothing expected, data %h",
                                              m_tdata));
                else
                begin
                    want = clicks_due.pop_front();
                    if (m_tuser[0] !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  m_tuser[0], want.status));
                    if (m_tdata[15:0] !== want.clicks)
                        report_mismatch($sformatf("click_count %0d, expected %0d",
                                                  m_tdata[15:0], want.clicks));
                    if (m_tdata[31:16] !== want.shown)
                        report_mismatch($sformatf("shown_value %0d, expected %0d",
                                                  m_tdata[31:16], want.shown));
                end
            end

            awaiting = clicks_due.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// HTTP body number to click count: testbench top
// Sends whole HTTP responses byte by byte, each closed by an end beat, under
// several modulus settings with random gaps on both channels and one long
// receiver stall. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbnc_pkg::*;

    localparam int RANDOM_BEATS = 650;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int   mismatches;
    int   awaiting;
    int   beats_sent = 0;
    bit   quiet      = 1'b0;
    bit   hold_req   = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    http_body_number_to_click_count dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hbnc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mismatches(mismatches),
        .awaiting  (awaiting)
    );

    // Receiver: random back-pressure, or one long stall when asked for.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= 18);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back beats need no extra toggle.
    task automatic send_beat(input logic op, input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= b;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(OP_BYTE, b);
        beats_sent++;
    endtask

    task automatic send_end();
        send_beat(OP_END, 8'($urandom_range(0, 255)));
        beats_sent++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] non_digit_byte();
        logic [7:0] b;
        do
            b = text_byte();
        while (b >= CH_ZERO && b <= CH_ZERO + DIGIT_MAX);
        return b;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(0, 3) != 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_header();
        int lines;
        int len;
        lines = $urandom_range(0, 2);
        for (int i = 0; i < lines; i++)
        begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++)
                send_byte(text_byte());
            send_line_end();
        end
        // Blank line; a stray CR between the two LFs must not matter.
        if (lines == 0)
            send_byte(CH_LF);
        if ($urandom_range(0, 3) == 0)
            send_byte(CH_CR);
        send_line_end();
    endtask

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Bytes that the parser ignores.
    task automatic send_junk(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_response();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            send_header();
            // Mostly short numbers; six or seven digits drive saturation.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
            send_digits(len);
            if ($urandom_range(0, 2) != 0)
            begin
                send_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
                send_junk($urandom_range(0, 3));
            end
        end
        else if (kind < 80)
        begin
            send_header();
            send_digits($urandom_range(0, 3));
            send_byte(non_digit_byte());
            send_junk($urandom_range(0, 3));
        end
        else
        begin
            // Raw noise, usually ending before the header is complete.
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
                send_byte(($urandom_range(0, 4) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
        end
        send_end();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_modulus(input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] settings[PHASES];
        int          goal;

        settings[0] = 16'd1;
        settings[1] = 16'd65535;
        settings[2] = 16'd0;
        settings[3] = 16'd7;
        settings[4] = 16'($urandom_range(2, 65534));
        settings[5] = MODULUS_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // End beat before any header: number 0 is applied.
        send_end();
        // Stray CR between the LFs, then a number that saturates.
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        repeat (5) send_byte(CH_ZERO + DIGIT_MAX);
        send_end();
        // Empty body line: a backward step down to zero.
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_end();
        // A non-digit body byte rejects the update.
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(CH_ZERO + 8'd7);
        send_byte("x");
        send_end();
        // Bytes after the line end are ignored.
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte("1");
        send_byte("2");
        send_byte(CH_CR);
        send_byte("5");
        send_end();

        beats_sent = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_modulus(settings[p]);
            quiet = (p == 3);
            if (p == 1)
                hold_req = 1'b1;
            goal = (RANDOM_BEATS * (p + 1)) / PHASES;
            while (beats_sent < goal)
                send_random_response();
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaiting == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb failed");
        $finish;
    end

endmodule
